[hw/rtl/qlss_pkg.sv]
`default_nettype none
package qlss_pkg;

  localparam int unsigned MaxSlots = 32;
  localparam int unsigned FracBits = 16;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_OVERHEAR = 2'd1,
    MODE_CONFIRM  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_CALC,
    ST_MUL_A,
    ST_WRITE,
    ST_OUT
  } state_e;

  // operation broadcast during one rotation of the ring; cells other than 0 see decay as a shift
  typedef enum logic [1:0] {
    OP_SHIFT = 2'd0,
    OP_DECAY = 2'd1,
    OP_INC   = 2'd2,
    OP_SETQ  = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic       rotate;
    cell_op_e   op;
  } cell_ctrl_t;

  localparam int unsigned RegIsSink      = 0;
  localparam int unsigned RegFrameLength = 1;
  localparam int unsigned RegLearnRate   = 2;
  localparam int unsigned RegDiscount    = 3;
  localparam int unsigned RegDecay       = 4;
  localparam int unsigned RegRewardOk    = 5;
  localparam int unsigned RegRewardFail  = 6;
  localparam int unsigned RegSendChance  = 7;

  localparam int unsigned ExploreLimit = 10000;

endpackage
`default_nettype wire

[hw/rtl/qlss_cell.sv]
`default_nettype none
// one slot of the ring: holds a Q value and a traffic score, hands both on
module qlss_cell
  import qlss_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic               sel_i,
  input  wire logic [16:0]        decay_i,
  input  wire logic signed [31:0] new_q_i,
  input  wire logic signed [31:0] q_i,
  input  wire logic [31:0]        score_i,
  output logic signed [31:0]      q_o,
  output logic [31:0]             score_o
);
  logic signed [31:0] q_q, q_d;
  logic [31:0] score_q, score_d;
  logic [48:0] prod;
  logic [32:0] inc;

  // the incoming score is the one processed, so each value passes the head once
  assign prod = 49'(score_i) * 49'(decay_i);
  assign inc  = 33'(score_i) + (33'd1 << FracBits);

  always_comb begin
    q_d = q_q;
    score_d = score_q;
    if (ctrl_i.rotate) begin
      q_d = q_i;
      score_d = score_i;
      case (ctrl_i.op)
        OP_DECAY: begin
          if ((prod >> FracBits) > 49'hFFFF_FFFF) score_d = 32'hFFFF_FFFF;
          else score_d = 32'(prod >> FracBits);
        end
        OP_INC: if (sel_i) score_d = inc[32] ? 32'hFFFF_FFFF : inc[31:0];
        OP_SETQ: if (sel_i) q_d = new_q_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
      score_q <= '0;
    end else begin
      q_q <= q_d;
      score_q <= score_d;
    end
  end

  assign q_o = q_q;
  assign score_o = score_q;
endmodule
`default_nettype wire

[hw/rtl/q_learning_slot_selector_unit.sv]
`default_nettype none
// Q-learning slot selector. Slot state sits in a ring of MaxSlots cells that
// rotates one place per cycle while a walk or a write is under way; every walk
// covers the full ring once so slot 0 is back at the head when it ends. Items
// are taken one at a time and the input stalls while one is in work. An
// overheard beat reduces the slot number modulo frame length one bit per cycle,
// then makes one rotation; a tick off a frame boundary only does the reduction;
// a boundary tick does the reduction and one rotation, then holds while an
// earlier pick still waits on the output stall; a confirm makes one rotation to
// read, a multiply step for the discounted maximum and one for the learning rate,
// then one rotation to write. The explore product is built alongside the
// remainder. Sink mode and the none mode do not stall the input and give nothing.
module q_learning_slot_selector_unit
  import qlss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [47:0] slot_number_i,
  input  wire logic [15:0] rand_action_i,
  input  wire logic [15:0] rand_send_i,
  input  wire logic        send_ok_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       chosen_slot_o,
  output logic             send_now_o,
  output logic             explored_o
);
  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW = $clog2(MaxSlots + 1);
  localparam int unsigned LenW = (CntW > 6) ? CntW : 6;

  // configuration
  logic        is_sink_q;
  logic [5:0]  frame_length_q;
  logic [16:0] learn_rate_q, discount_q, decay_q, send_chance_q;
  logic [23:0] reward_ok_q, reward_fail_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_sink_q <= 1'b0;
      frame_length_q <= 6'd16;
      learn_rate_q <= 17'd6554;
      discount_q <= 17'd58982;
      decay_q <= 17'd58982;
      reward_ok_q <= 24'd65536;
      reward_fail_q <= 24'hFF0000;
      send_chance_q <= 17'd32768;
    end else if (wr_en) begin
      case (reg_idx)
        3'(RegIsSink):      is_sink_q <= pwdata[0];
        3'(RegFrameLength): frame_length_q <= pwdata[5:0];
        3'(RegLearnRate):   learn_rate_q <= pwdata[16:0];
        3'(RegDiscount):    discount_q <= pwdata[16:0];
        3'(RegDecay):       decay_q <= pwdata[16:0];
        3'(RegRewardOk):    reward_ok_q <= pwdata[23:0];
        3'(RegRewardFail):  reward_fail_q <= pwdata[23:0];
        3'(RegSendChance):  send_chance_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      3'(RegIsSink):      prdata = {31'd0, is_sink_q};
      3'(RegFrameLength): prdata = {26'd0, frame_length_q};
      3'(RegLearnRate):   prdata = {15'd0, learn_rate_q};
      3'(RegDiscount):    prdata = {15'd0, discount_q};
      3'(RegDecay):       prdata = {15'd0, decay_q};
      3'(RegRewardOk):    prdata = {{8{reward_ok_q[23]}}, reward_ok_q};
      3'(RegRewardFail):  prdata = {{8{reward_fail_q[23]}}, reward_fail_q};
      3'(RegSendChance):  prdata = {15'd0, send_chance_q};
      default:            prdata = '0;
    endcase
  end

  // effective length
  logic [CntW-1:0] len;
  always_comb begin
    if (frame_length_q == 6'd0) len = CntW'(1);
    else if (LenW'(frame_length_q) > LenW'(MaxSlots)) len = CntW'(MaxSlots);
    else len = CntW'(frame_length_q);
  end

  // ring
  cell_ctrl_t ctrl;
  logic signed [31:0] q_ring [MaxSlots];
  logic [31:0] s_ring [MaxSlots];
  logic [IdxW-1:0] sel_idx_q;
  logic signed [31:0] new_q;
  logic [CntW-1:0] pos_q;  // slot index currently at the head

  for (genvar g = 0; g < MaxSlots; g++) begin : g_cell
    localparam int unsigned Prev = (g + MaxSlots - 1) % MaxSlots;
    cell_ctrl_t c;
    always_comb begin
      c = ctrl;
      // decay only the first len slots (as they come in to cell 0 from the tail)
      if (g == 0 && ctrl.op == OP_DECAY && pos_q >= len) c.op = OP_SHIFT;
      if (g != 0 && ctrl.op == OP_DECAY) c.op = OP_SHIFT;
    end
    qlss_cell u_cell (
      .clk_i, .rst_ni,
      .ctrl_i  (c),
      .sel_i   (g == 0 && pos_q[IdxW-1:0] == sel_idx_q),
      .decay_i (decay_q),
      .new_q_i (new_q),
      .q_i     (q_ring[Prev]),
      .score_i (s_ring[Prev]),
      .q_o     (q_ring[g]),
      .score_o (s_ring[g])
    );
  end
  // the tail holds the slot that enters cell 0 next; pos_q counts those

  // sequencer
  state_e st_q, st_d;
  mode_e  mode_q;
  logic [47:0] asn_q;
  logic [15:0] ra_q, rs_q;
  logic        ok_q;
  logic [LenW-1:0] rem_q;
  logic [5:0]  bit_q;
  logic signed [31:0] maxq_q, curq_q;
  logic [IdxW-1:0] maxi_q, mini_q, cur_q;
  logic [31:0] mins_q;
  logic [63:0] acc_q;
  logic explore_q;
  logic [4:0] out_slot_q;
  logic out_send_q, out_exp_q, out_valid_q;

  // slot number enters msb first: remainder and explore product share the bit
  logic        asn_bit;
  logic [LenW:0] rem_sh;
  logic [63:0] acc_nx;
  assign asn_bit = asn_q[6'd47 - bit_q];
  assign rem_sh = {rem_q, asn_bit};
  assign acc_nx = {acc_q[62:0], 1'b0} + (asn_bit ? 64'(ra_q) : 64'd0);

  logic signed [31:0] tail_q;
  logic [31:0] tail_s;
  assign tail_q = q_ring[MaxSlots-1];
  assign tail_s = s_ring[MaxSlots-1];

  // decayed score of the incoming slot, for the min search
  logic [48:0] dprod;
  logic [31:0] dscore;
  assign dprod = 49'(tail_s) * 49'(decay_q);
  assign dscore = ((dprod >> FracBits) > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                        : 32'(dprod >> FracBits);

  logic signed [49:0] gm, lm;
  logic signed [49:0] delta_w;
  logic signed [63:0] nq_w;

  assign in_stall_o = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign chosen_slot_o = out_slot_q;
  assign send_now_o = out_send_q;
  assign explored_o = out_exp_q;

  always_comb begin
    st_d = st_q;
    ctrl.rotate = 1'b0;
    ctrl.op = OP_SHIFT;
    case (st_q)
      ST_IDLE: if (in_valid_i && !is_sink_q && mode_i != MODE_NONE) begin
        st_d = (mode_e'(mode_i) == MODE_CONFIRM) ? ST_WALK : ST_MOD;
      end
      ST_MOD: if (bit_q == 6'd47) begin
        if (mode_q == MODE_OVERHEAR) st_d = ST_WALK;
        else if (rem_sh >= (LenW+1)'(len) ? (rem_sh - (LenW+1)'(len)) == '0
                                           : rem_sh == '0) st_d = ST_WALK;
        else st_d = ST_IDLE;
      end
      ST_WALK: begin
        ctrl.rotate = 1'b1;
        case (mode_q)
          MODE_TICK: ctrl.op = OP_DECAY;
          MODE_OVERHEAR: ctrl.op = OP_INC;
          default: ctrl.op = OP_SHIFT;
        endcase
        if (pos_q == CntW'(MaxSlots - 1)) begin
          case (mode_q)
            MODE_CONFIRM: st_d = ST_CALC;
            MODE_TICK: st_d = ST_OUT;
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_CALC: st_d = ST_MUL_A;
      ST_MUL_A: st_d = ST_WRITE;
      ST_WRITE: begin
        ctrl.rotate = 1'b1;
        ctrl.op = OP_SETQ;
        if (pos_q == CntW'(MaxSlots - 1)) st_d = ST_IDLE;
      end
      ST_OUT: if (!out_valid_q || !out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_slot_q <= '0;
      out_exp_q <= 1'b0;
      out_send_q <= 1'b0;
      cur_q <= '0;
      pos_q <= '0;
    end else begin
      if (ctrl.rotate) pos_q <= (pos_q == CntW'(MaxSlots - 1)) ? '0 : pos_q + 1'b1;
      if (st_q == ST_OUT && st_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
        out_slot_q <= 5'(explore_q ? mini_q : maxi_q);
        out_exp_q <= explore_q;
        out_send_q <= (17'(rs_q) < send_chance_q);
        cur_q <= explore_q ? mini_q : maxi_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        mode_q <= mode_e'(mode_i);
        asn_q <= slot_number_i;
        ra_q <= rand_action_i;
        rs_q <= rand_send_i;
        ok_q <= send_ok_i;
        rem_q <= '0;
        bit_q <= '0;
        sel_idx_q <= cur_q;
        acc_q <= '0;
      end
      ST_MOD: begin
        rem_q <= (rem_sh >= (LenW+1)'(len)) ? LenW'(rem_sh - (LenW+1)'(len))
                                             : LenW'(rem_sh);
        bit_q <= bit_q + 1'b1;
        acc_q <= acc_nx;
        if (bit_q == 6'd47) sel_idx_q <= IdxW'((rem_sh >= (LenW+1)'(len))
                                       ? rem_sh - (LenW+1)'(len) : rem_sh);
        explore_q <= (ra_q < 16'(1 << (FracBits - 1))) &&
                     (acc_nx < (64'(ExploreLimit) << FracBits));
      end
      ST_WALK: begin
        if (pos_q < len) begin
          if (pos_q == '0 || tail_q > maxq_q) begin
            maxq_q <= tail_q; maxi_q <= pos_q[IdxW-1:0];
          end
          if (pos_q == '0 || dscore < mins_q) begin
            mins_q <= dscore; mini_q <= pos_q[IdxW-1:0];
          end
        end
        if (pos_q[IdxW-1:0] == cur_q) curq_q <= tail_q;
      end
      ST_CALC: acc_q <= 64'($signed(50'(discount_q)) * 50'(maxq_q));
      ST_MUL_A: acc_q <= 64'(learn_rate_q) * 64'(delta_w);
      ST_WRITE: ;
      default: ;
    endcase
  end

  // arithmetic of the update, floor by arithmetic shift
  assign gm = 50'($signed(acc_q) >>> FracBits);
  assign delta_w = 50'(signed'(ok_q ? reward_ok_q : reward_fail_q)) + gm - 50'(curq_q);
  assign lm = 50'($signed(acc_q) >>> FracBits);
  assign nq_w = 64'(curq_q) + 64'(lm);
  // saturated new Q, steady through the whole write rotation
  assign new_q = (nq_w > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
               : ((nq_w < -64'sh8000_0000) ? 32'sh8000_0000 : 32'(nq_w));
endmodule
`default_nettype wire

[tb/sv/q_learning_slot_selector_unit_checker.sv]
`timescale 1ns / 1ps
module q_learning_slot_selector_unit_checker
  import qlss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [47:0] slot_number_i,
  input  wire logic [15:0] rand_action_i,
  input  wire logic [15:0] rand_send_i,
  input  wire logic        send_ok_i,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [4:0]  chosen_slot_o,
  input  wire logic        send_now_o,
  input  wire logic        explored_o,
  output int               fail_count,
  output int               pending_picks
);

  typedef struct packed {
    logic [4:0] slot;
    logic       send;
    logic       expl;
  } pick_t;

  pick_t pick_q[$];

  logic        sink_r;
  logic [5:0]  len_r;
  logic [16:0] alpha_r, gamma_r, sigma_r, chance_r;
  logic signed [23:0] rew_ok_r, rew_fail_r;
  logic signed [31:0] qv [32];
  logic [31:0] score [32];
  logic [4:0]  cur_slot;

  assign pending_picks = pick_q.size();

  function automatic int unsigned frame_len();
    if (len_r == 0) return 1;
    if (len_r > 32) return 32;
    return len_r;
  endfunction

  function automatic int unsigned best_q(int unsigned n);
    int unsigned b;
    b = 0;
    for (int unsigned i = 1; i < n; i++) if (qv[i] > qv[b]) b = i;
    return b;
  endfunction

  task automatic predict_beat(logic [1:0] md, logic [47:0] sn, logic [15:0] ra,
                              logic [15:0] rs, logic ok);
    int unsigned n, s, b;
    logic [63:0] v;
    longint r, mq, q, dl, nq;
    logic expl;
    pick_t p;
    n = frame_len();
    if (sink_r) return;
    case (mode_e'(md))
      MODE_OVERHEAR: begin
        s = 32'(sn % n);
        v = {32'd0, score[s]} + 64'h10000;
        score[s] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end
      MODE_CONFIRM: begin
        r = ok ? longint'(rew_ok_r) : longint'(rew_fail_r);
        mq = qv[best_q(n)];
        q = qv[cur_slot];
        dl = r + ((longint'(gamma_r) * mq) >>> 16) - q;
        nq = q + ((longint'(alpha_r) * dl) >>> 16);
        if (nq > 64'sd2147483647) nq = 64'sd2147483647;
        if (nq < -64'sd2147483648) nq = -64'sd2147483648;
        qv[cur_slot] = nq[31:0];
      end
      MODE_TICK: begin
        if (sn % n == 0) begin
          for (int unsigned i = 0; i < n; i++) begin
            v = ({32'd0, score[i]} * sigma_r) >> 16;
            score[i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
          end
          expl = (ra < 16'h8000) && ({48'd0, ra} * {16'd0, sn} < (64'd10000 << 16));
          if (expl) begin
            b = 0;
            for (int unsigned i = 1; i < n; i++) if (score[i] < score[b]) b = i;
          end else begin
            b = best_q(n);
          end
          cur_slot = b[4:0];
          p.slot = cur_slot;
          p.send = {1'b0, rs} < chance_r;
          p.expl = expl;
          pick_q.push_back(p);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t e;
    if (!rst_ni) begin
      sink_r <= 1'b0; len_r <= 6'd16; alpha_r <= 17'd6554; gamma_r <= 17'd58982;
      sigma_r <= 17'd58982;
      rew_ok_r <= 24'sd65536; rew_fail_r <= -24'sd65536; chance_r <= 17'd32768;
      for (int i = 0; i < 32; i++) begin
        qv[i] = 0;
        score[i] = 0;
      end
      cur_slot = 0;
      fail_count <= 0;
      pick_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegIsSink:      sink_r <= pwdata[0];
          RegFrameLength: len_r <= pwdata[5:0];
          RegLearnRate:   alpha_r <= pwdata[16:0];
          RegDiscount:    gamma_r <= pwdata[16:0];
          RegDecay:       sigma_r <= pwdata[16:0];
          RegRewardOk:    rew_ok_r <= pwdata[23:0];
          RegRewardFail:  rew_fail_r <= pwdata[23:0];
          RegSendChance:  chance_r <= pwdata[16:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (pick_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected pick beat slot %0d", chosen_slot_o);
          fail_count <= fail_count + 1;
        end else begin
          e = pick_q.pop_front();
          if (e != {chosen_slot_o, send_now_o, explored_o}) begin
            if (fail_count < 10)
              $display("pick mismatch: exp slot %0d send %0b expl %0b, got %0d %0b %0b",
                       e.slot, e.send, e.expl, chosen_slot_o, send_now_o, explored_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        predict_beat(mode_i, slot_number_i, rand_action_i, rand_send_i, send_ok_i);
    end
  end

endmodule

[tb/sv/q_learning_slot_selector_unit_tb.sv]
`timescale 1ns / 1ps
module q_learning_slot_selector_unit_tb;
  import qlss_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  mode_i = 0;
  logic [47:0] slot_number_i = 0;
  logic [15:0] rand_action_i = 0, rand_send_i = 0;
  logic        send_ok_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [4:0]  chosen_slot_o;
  logic        send_now_o, explored_o;
  int          fail_count, pending_picks;
  int          cycle_count = 0;
  bit          calm = 0;
  int          cur_len = 16;

  localparam int CycleLimit = 1500000;

  always #1 clk_i = ~clk_i;

  q_learning_slot_selector_unit dut (.*);
  q_learning_slot_selector_unit_checker chk (.*);

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk_i);
      out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("q_learning_slot_selector_unit_tb: errors");
      $finish;
    end
  end

  task automatic reg_write(int unsigned idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // valid stays high after the accepting edge; the next beat or an idle takes over
  task automatic send_beat(logic [1:0] md, logic [47:0] sn, logic [15:0] ra,
                           logic [15:0] rs, logic ok);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1; mode_i <= md; slot_number_i <= sn;
    rand_action_i <= ra; rand_send_i <= rs; send_ok_i <= ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending_picks != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic random_beat();
    logic [47:0] sn;
    int unsigned k;
    k = $urandom_range(0, 99);
    sn = (k < 50) ? 48'($urandom_range(0, 40000)) : 48'({$urandom, $urandom});
    if (k < 30) sn = sn - (sn % cur_len);
    if (k < 40)
      send_beat(MODE_TICK, sn, 16'($urandom), 16'($urandom), 1'($urandom));
    else if (k < 75)
      send_beat(MODE_OVERHEAR, sn, 16'($urandom), 16'($urandom), 1'($urandom));
    else if (k < 97)
      send_beat(MODE_CONFIRM, sn, 16'($urandom), 16'($urandom), 1'($urandom));
    else
      send_beat(MODE_NONE, sn, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed
    send_beat(MODE_TICK, 0, 16'h7FFF, 16'h0000, 0);
    send_beat(MODE_OVERHEAR, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1);
    send_beat(MODE_CONFIRM, 0, 0, 0, 1);
    send_beat(MODE_CONFIRM, 0, 0, 0, 0);
    send_beat(MODE_TICK, 48'hFFFF_FFFF_FFF0, 16'h0001, 16'h7FFF, 0);
    send_beat(MODE_TICK, 32, 16'h8000, 16'h8000, 0);
    send_beat(MODE_TICK, 3, 0, 0, 0);
    send_beat(MODE_NONE, 0, 0, 0, 0);
    send_beat(MODE_TICK, 20000, 16'h7FFF, 16'hFFFF, 1);
    drain();
    reg_write(RegFrameLength, 0);
    reg_write(RegLearnRate, 65536);
    reg_write(RegDiscount, 65536);
    reg_write(RegDecay, 17'h1FFFF);
    reg_write(RegRewardOk, 32'h007F_FFFF);
    reg_write(RegRewardFail, 32'h0080_0000);
    reg_write(RegSendChance, 0);
    for (int i = 0; i < 6; i++) send_beat(MODE_CONFIRM, 48'(i), 0, 16'($urandom), i[0]);
    send_beat(MODE_OVERHEAR, 5, 0, 0, 0);
    send_beat(MODE_TICK, 7, 16'hFFFF, 16'h0000, 0);
    drain();
    reg_write(RegIsSink, 1);
    send_beat(MODE_TICK, 0, 0, 0, 0);
    send_beat(MODE_CONFIRM, 0, 0, 0, 1);
    drain();
    reg_write(RegIsSink, 0);
    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      cur_len = (ph == 0) ? 2 : (ph == 1) ? 32 : (ph == 2) ? 63 : $urandom_range(2, 32);
      reg_write(RegFrameLength, cur_len);
      reg_write(RegLearnRate, (ph == 3) ? 0 : $urandom_range(0, 65536));
      reg_write(RegDiscount, (ph == 4) ? 65536 : $urandom_range(0, 65536));
      reg_write(RegDecay, (ph == 5) ? 0 : $urandom_range(0, 65536));
      reg_write(RegRewardOk, $urandom);
      reg_write(RegRewardFail, $urandom);
      reg_write(RegSendChance, (ph == 6) ? 65536 : $urandom_range(0, 65536));
      reg_write(RegIsSink, (ph == 7) ? 1 : 0);
      if (cur_len > 32) cur_len = 32;
      if (ph == 8) calm = 1;
      repeat (100) random_beat();
      drain();
    end
    if (fail_count == 0)
      $display("q_learning_slot_selector_unit_tb: clean");
    else
      $display("q_learning_slot_selector_unit_tb: errors");
    $finish;
  end

endmodule
